// ===== rtl/core/lru_page_cache_directory_top_defines.svh =====
// assertion macros for the page cache directory
`ifndef LRU_PAGE_CACHE_DIRECTORY_TOP_DEFINES_SVH
`define LRU_PAGE_CACHE_DIRECTORY_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LPCD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpcd assertion failed");

// antecedent implies consequent in the next cycle
`define LPCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpcd assertion failed");

`else

`define LPCD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LPCD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/lpcd_pkg.sv =====
// shared types and constants of the page cache directory
`default_nettype none

package lpcd_pkg;

   localparam int PAGE_ID_W       = 32;
   localparam int SLOT_W          = 4;
   localparam int DEFAULT_ENTRIES = 16;
   localparam int DEFAULT_ID_BITS = 32;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic commit;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/lpcd_ctrl.sv =====
// controller state machine of the page cache directory
`default_nettype none

module lpcd_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   output lpcd_pkg::cmd_type cmd
);
   import lpcd_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.lookup = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/lpcd_dpath.sv =====
// tag, recency and response datapath of the page cache directory
`default_nettype none

module lpcd_dpath #(
   parameter int ENTRIES = lpcd_pkg::DEFAULT_ENTRIES,
   parameter int ID_BITS = lpcd_pkg::DEFAULT_ID_BITS
) (
   input  wire                               clock,
   input  wire                               reset,
   input  lpcd_pkg::cmd_type                 cmd,
   input  wire  [lpcd_pkg::PAGE_ID_W-1:0]    req_page_id,
   input  wire                               req_mark_dirty,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [lpcd_pkg::SLOT_W-1:0]       rsp_slot,
   output logic                              rsp_evicted,
   output logic [lpcd_pkg::PAGE_ID_W-1:0]    rsp_evicted_page_id,
   output logic                              rsp_write_back
);
   import lpcd_pkg::*;

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int OCC_W   = $clog2(ENTRIES + 1);
   localparam int WIDE_ID = (ID_BITS > PAGE_ID_W) ? ID_BITS : PAGE_ID_W;
   localparam int WIDE_SL = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   // directory state
   logic [ID_BITS-1:0] tag_ff   [ENTRIES];
   logic [IDX_W-1:0]   rank_ff  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] dirty_ff;
   logic [OCC_W-1:0]   occ_ff;

   // latched request and lookup results
   logic [ID_BITS-1:0] req_id_ff;
   logic               req_dirty_ff;
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] victim_ff;
   logic               full_ff;

   logic [WIDE_ID-1:0] id_ext;
   logic [ENTRIES-1:0] match_in;
   logic [ENTRIES-1:0] victim_in;

   logic               hit;
   logic [IDX_W-1:0]   match_idx;
   logic [IDX_W-1:0]   victim_idx;
   logic [IDX_W-1:0]   free_idx;
   logic [IDX_W-1:0]   sel_idx;
   logic [IDX_W-1:0]   sel_rank;
   logic [ENTRIES-1:0] sel_vec;
   logic [ENTRIES-1:0] age_vec;
   logic               evict;
   logic [WIDE_ID-1:0] ev_ext;
   logic [WIDE_SL-1:0] slot_ext;

   // response registers
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_evicted_ff;
   logic [PAGE_ID_W-1:0] rsp_ev_id_ff;
   logic                 rsp_wb_ff;

   assign id_ext = WIDE_ID'(req_page_id);

   // per-entry compare against the latched id
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_in[i]  = valid_ff[i] && (tag_ff[i] == req_id_ff);
         victim_in[i] = valid_ff[i] && (rank_ff[i] == IDX_W'(ENTRIES - 1));
      end
   end

   always_comb begin
      match_idx  = '0;
      victim_idx = '0;
      free_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (match_ff[i]) match_idx = match_idx | IDX_W'(i);
         if (victim_ff[i]) victim_idx = victim_idx | IDX_W'(i);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_idx = IDX_W'(i);
      end
   end

   assign hit   = |match_ff;
   assign evict = !hit && full_ff;

   always_comb begin
      priority if (hit) begin
         sel_idx = match_idx;
      end else if (full_ff) begin
         sel_idx = victim_idx;
      end else begin
         sel_idx = free_idx;
      end
   end

   assign sel_rank = rank_ff[sel_idx];
   assign ev_ext   = WIDE_ID'(tag_ff[sel_idx]);
   assign slot_ext = WIDE_SL'(sel_idx);

   // entries more recent than the chosen one age by one; on a miss all of them
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         sel_vec[i] = (sel_idx == IDX_W'(i));
         age_vec[i] = valid_ff[i] && !sel_vec[i] && (!hit || (rank_ff[i] < sel_rank));
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_id_ff    <= id_ext[ID_BITS-1:0];
         req_dirty_ff <= req_mark_dirty;
      end
      if (cmd.lookup) begin
         match_ff  <= match_in;
         victim_ff <= victim_in;
         full_ff   <= (occ_ff == OCC_W'(ENTRIES));
      end
      if (cmd.commit) begin
         if (!hit) tag_ff[sel_idx] <= req_id_ff;
         rsp_hit_ff     <= hit;
         rsp_slot_ff    <= slot_ext[SLOT_W-1:0];
         rsp_evicted_ff <= evict;
         rsp_ev_id_ff   <= evict ? ev_ext[PAGE_ID_W-1:0] : '0;
         rsp_wb_ff      <= evict && dirty_ff[sel_idx];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) rank_ff[i] <= '0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (sel_vec[i]) begin
                  rank_ff[i]  <= '0;
                  valid_ff[i] <= 1'b1;
                  dirty_ff[i] <= (hit && dirty_ff[i]) || req_dirty_ff;
               end else if (age_vec[i]) begin
                  rank_ff[i] <= rank_ff[i] + 1'b1;
               end
            end
            if (!hit && !full_ff) occ_ff <= occ_ff + 1'b1;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_evicted         = rsp_evicted_ff;
   assign rsp_evicted_page_id = rsp_ev_id_ff;
   assign rsp_write_back      = rsp_wb_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lru_page_cache_directory_top.sv =====
// top level of the fully associative lru page cache directory
// the result strobe follows the accepting edge through lookup, update and the result register
// a new transaction is accepted only in idle, after the lookup/update sequence of the controller
// results cannot be stalled; each is shown for exactly one cycle on rsp_valid
// synchronous reset empties the directory: all entries invalid, clean, rank zero
`default_nettype none
`include "lru_page_cache_directory_top_defines.svh"

module lru_page_cache_directory_top #(
   parameter int ENTRIES = lpcd_pkg::DEFAULT_ENTRIES,
   parameter int ID_BITS = lpcd_pkg::DEFAULT_ID_BITS
) (
   input  wire                            clock,
   input  wire                            reset,
   // request transaction
   input  wire                            start,
   output logic                           busy,
   input  wire                            req_func,
   input  wire  [lpcd_pkg::PAGE_ID_W-1:0] req_page_id,
   input  wire                            req_mark_dirty,
   // response transaction
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic [lpcd_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                           rsp_evicted,
   output logic [lpcd_pkg::PAGE_ID_W-1:0] rsp_evicted_page_id,
   output logic                           rsp_write_back
);
   import lpcd_pkg::*;

   cmd_type cmd;

   // get and create behave alike: a create of a held id just refreshes it,
   // so the function code does not steer the datapath
   logic create_req;
   assign create_req = start && req_func;

   // sequencing: load on accept, parallel lookup, then commit and respond
   lpcd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // tags, recency ranks, dirty marks and response registers
   lpcd_dpath #(
      .ENTRIES (ENTRIES),
      .ID_BITS (ID_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_page_id         (req_page_id),
      .req_mark_dirty      (req_mark_dirty),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_slot            (rsp_slot),
      .rsp_evicted         (rsp_evicted),
      .rsp_evicted_page_id (rsp_evicted_page_id),
      .rsp_write_back      (rsp_write_back)
   );

   // an accepted transaction, get or create, yields its result through lookup, update and result register
   `LPCD_ASSERT_IMPLY(a_accept_to_rsp, clock, reset, (start || create_req) && !busy, ##3 rsp_valid)
   // a result only appears once the controller is back to idle
   `LPCD_ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   // commit is followed by exactly one result strobe
   `LPCD_ASSERT_NEXT(a_commit_rsp, clock, reset, cmd.commit, rsp_valid && !busy)
   // an eviction only happens on a miss, and write-back only with eviction
   `LPCD_ASSERT_IMPLY(a_evict_miss, clock, reset, rsp_evicted || rsp_write_back, !rsp_hit && rsp_evicted)

endmodule

`default_nettype wire
